/* sv/rri_pkg.sv */
package rri_pkg;

  // epsilon on t, in Q16.16 units
  localparam logic [31:0] T_EPSILON = 32'd66;

  // quotient bits produced by the divider chain
  localparam int unsigned QuotW = 32;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 63;
  localparam logic [CfgIdxW-1:0] CFG_CORNER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIDE_ONE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SIDE_TWO = 2'd2;

  // packed vector, x in the lowest bits
  typedef struct packed {
    logic signed [20:0] z;
    logic signed [20:0] y;
    logic signed [20:0] x;
  } vec3_t;

  // ray data that rides along with the division
  typedef struct packed {
    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic signed [20:0] dz;
    logic signed [21:0] ex;
    logic signed [21:0] ey;
    logic signed [21:0] ez;
    logic [31:0]        tlo;
    logic [31:0]        thi;
  } side_t;

  // state handed from one divider cell to the next
  typedef struct packed {
    logic              valid;
    logic              miss;
    logic [63:0]       rem;
    logic [QuotW-1:0]  pend;
    logic [QuotW-1:0]  quot;
    logic [63:0]       dmag;
    side_t             side;
  } div_t;

endpackage

/* sv/rri_if.sv */
interface rri_ray_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] ray_origin_x;
  logic signed [20:0] ray_origin_y;
  logic signed [20:0] ray_origin_z;
  logic signed [20:0] ray_dir_x;
  logic signed [20:0] ray_dir_y;
  logic signed [20:0] ray_dir_z;
  logic [31:0]        t_lower;
  logic [31:0]        t_upper;

  modport source (
    output valid, ray_origin_x, ray_origin_y, ray_origin_z,
           ray_dir_x, ray_dir_y, ray_dir_z, t_lower, t_upper,
    input  ready
  );
  modport sink (
    input  valid, ray_origin_x, ray_origin_y, ray_origin_z,
           ray_dir_x, ray_dir_y, ray_dir_z, t_lower, t_upper,
    output ready
  );
endinterface

interface rri_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] hit_t;

  modport source (output valid, hit, hit_t, input ready);
  modport sink (input valid, hit, hit_t, output ready);
endinterface

/* sv/rri_front.sv */
module rri_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  rri_ray_if.sink         ray_i,
  input  rri_pkg::vec3_t  corner_i,
  input  rri_pkg::vec3_t  side1_i,
  input  rri_pkg::vec3_t  side2_i,
  output rri_pkg::div_t   div_o
);
  import rri_pkg::*;

  // stage 1: cross product terms and corner offset
  logic               v1_q;
  logic signed [41:0] pa0_q, pa1_q, pa2_q, pb0_q, pb1_q, pb2_q;
  side_t              sd1_q;
  // stage 2: normal
  logic               v2_q;
  logic signed [42:0] n0_q, n1_q, n2_q;
  side_t              sd2_q;
  // stage 3: dot product terms
  logic               v3_q;
  logic signed [63:0] dn0_q, dn1_q, dn2_q;
  logic signed [64:0] en0_q, en1_q, en2_q;
  side_t              sd3_q;
  // stage 4: dot products
  logic               v4_q;
  logic signed [63:0] den_q;
  logic signed [64:0] num_q;
  side_t              sd4_q;
  // stage 5: magnitudes
  logic               v5_q;
  logic               miss5_q;
  logic [63:0]        nmag_q, dmag_q;
  side_t              sd5_q;
  // stage 6: divider setup
  div_t               div_q;

  logic        num_neg, den_neg;
  logic [63:0] nmag_d, dmag_d;
  logic        ovf;

  assign ray_i.ready = en_i;

  assign num_neg = num_q[64];
  assign den_neg = den_q[63];
  assign nmag_d  = num_neg ? 64'(-num_q) : num_q[63:0];
  assign dmag_d  = den_neg ? 64'(-den_q) : den_q[63:0];
  assign ovf     = {16'd0, nmag_q} >= {dmag_q, 16'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      pa0_q <= '0; pa1_q <= '0; pa2_q <= '0; pb0_q <= '0; pb1_q <= '0; pb2_q <= '0;
      sd1_q <= '0; sd2_q <= '0; sd3_q <= '0; sd4_q <= '0; sd5_q <= '0;
      n0_q <= '0; n1_q <= '0; n2_q <= '0;
      dn0_q <= '0; dn1_q <= '0; dn2_q <= '0; en0_q <= '0; en1_q <= '0; en2_q <= '0;
      den_q <= '0; num_q <= '0;
      miss5_q <= 1'b0; nmag_q <= '0; dmag_q <= '0;
      div_q <= '0;
    end else if (en_i) begin
      // stage 1
      v1_q      <= ray_i.valid;
      pa0_q     <= 42'(side2_i.y) * 42'(side1_i.z);
      pb0_q     <= 42'(side2_i.z) * 42'(side1_i.y);
      pa1_q     <= 42'(side2_i.z) * 42'(side1_i.x);
      pb1_q     <= 42'(side2_i.x) * 42'(side1_i.z);
      pa2_q     <= 42'(side2_i.x) * 42'(side1_i.y);
      pb2_q     <= 42'(side2_i.y) * 42'(side1_i.x);
      sd1_q.dx  <= ray_i.ray_dir_x;
      sd1_q.dy  <= ray_i.ray_dir_y;
      sd1_q.dz  <= ray_i.ray_dir_z;
      sd1_q.ex  <= 22'(corner_i.x) - 22'(ray_i.ray_origin_x);
      sd1_q.ey  <= 22'(corner_i.y) - 22'(ray_i.ray_origin_y);
      sd1_q.ez  <= 22'(corner_i.z) - 22'(ray_i.ray_origin_z);
      sd1_q.tlo <= ray_i.t_lower;
      sd1_q.thi <= ray_i.t_upper;
      // stage 2
      v2_q  <= v1_q;
      n0_q  <= 43'(pa0_q) - 43'(pb0_q);
      n1_q  <= 43'(pa1_q) - 43'(pb1_q);
      n2_q  <= 43'(pa2_q) - 43'(pb2_q);
      sd2_q <= sd1_q;
      // stage 3
      v3_q  <= v2_q;
      dn0_q <= 64'(sd2_q.dx) * 64'(n0_q);
      dn1_q <= 64'(sd2_q.dy) * 64'(n1_q);
      dn2_q <= 64'(sd2_q.dz) * 64'(n2_q);
      en0_q <= 65'(sd2_q.ex) * 65'(n0_q);
      en1_q <= 65'(sd2_q.ey) * 65'(n1_q);
      en2_q <= 65'(sd2_q.ez) * 65'(n2_q);
      sd3_q <= sd2_q;
      // stage 4
      v4_q  <= v3_q;
      den_q <= dn0_q + dn1_q + dn2_q;
      num_q <= en0_q + en1_q + en2_q;
      sd4_q <= sd3_q;
      // stage 5: parallel ray or hit behind the origin
      v5_q    <= v4_q;
      miss5_q <= (den_q == '0) || ((nmag_d != '0) && (num_neg != den_neg));
      nmag_q  <= nmag_d;
      dmag_q  <= dmag_d;
      sd5_q   <= sd4_q;
      // stage 6: quotient overflow check, integer part preloaded as remainder
      div_q.valid <= v5_q;
      div_q.miss  <= miss5_q || ovf;
      div_q.rem   <= {16'd0, nmag_q[63:16]};
      div_q.pend  <= {nmag_q[15:0], 16'd0};
      div_q.quot  <= '0;
      div_q.dmag  <= dmag_q;
      div_q.side  <= sd5_q;
    end
  end

  assign div_o = div_q;

endmodule

/* sv/rri_div_cell.sv */
module rri_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rri_pkg::div_t  cell_i,
  output rri_pkg::div_t  cell_o
);
  import rri_pkg::*;

  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;
  div_t        cell_d, cell_q;

  // shift in the next dividend bit and try a subtract
  assign trial = {cell_i.rem, cell_i.pend[QuotW-1]};
  assign diff  = trial - {1'b0, cell_i.dmag};
  assign ge    = trial >= {1'b0, cell_i.dmag};

  always_comb begin
    cell_d      = cell_i;
    cell_d.rem  = ge ? diff[63:0] : trial[63:0];
    cell_d.pend = {cell_i.pend[QuotW-2:0], 1'b0};
    cell_d.quot = {cell_i.quot[QuotW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* sv/rri_back.sv */
module rri_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rri_pkg::div_t   div_i,
  input  rri_pkg::vec3_t  side1_i,
  input  rri_pkg::vec3_t  side2_i,
  rri_res_if.source       res_o
);
  import rri_pkg::*;

  logic [31:0]        tq;
  logic signed [32:0] tqs;

  // stage 1: window tests and t * dir
  logic               v1_q, miss1_q;
  logic [31:0]        t1_q;
  logic signed [53:0] p0_q, p1_q, p2_q;
  logic signed [21:0] ex1_q, ey1_q, ez1_q;
  // stage 2: offset of the hit point from the corner
  logic               v2_q, miss2_q;
  logic [31:0]        t2_q;
  logic signed [54:0] vx_q, vy_q, vz_q;
  // stage 3: projection terms and squared lengths
  logic               v3_q, miss3_q;
  logic [31:0]        t3_q;
  logic signed [75:0] ma0_q, ma1_q, ma2_q, mb0_q, mb1_q, mb2_q;
  logic signed [44:0] lsa_q, lsb_q;
  // stage 4: projections
  logic               v4_q, miss4_q;
  logic [31:0]        t4_q;
  logic signed [77:0] pa_q, pb_q, la_q, lb_q;
  // output register
  logic               out_v_q, hit_q;
  logic [31:0]        hit_t_q;

  logic inside_a, inside_b, hit_d;

  assign tq  = div_i.quot;
  assign tqs = {1'b0, tq};

  assign inside_a = !pa_q[77] && (pa_q <= la_q);
  assign inside_b = !pb_q[77] && (pb_q <= lb_q);
  assign hit_d    = !miss4_q && inside_a && inside_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; out_v_q <= 1'b0;
      miss1_q <= 1'b0; miss2_q <= 1'b0; miss3_q <= 1'b0; miss4_q <= 1'b0;
      t1_q <= '0; t2_q <= '0; t3_q <= '0; t4_q <= '0;
      p0_q <= '0; p1_q <= '0; p2_q <= '0; ex1_q <= '0; ey1_q <= '0; ez1_q <= '0;
      vx_q <= '0; vy_q <= '0; vz_q <= '0;
      ma0_q <= '0; ma1_q <= '0; ma2_q <= '0; mb0_q <= '0; mb1_q <= '0; mb2_q <= '0;
      lsa_q <= '0; lsb_q <= '0;
      pa_q <= '0; pb_q <= '0; la_q <= '0; lb_q <= '0;
      hit_q <= 1'b0; hit_t_q <= '0;
    end else if (en_i) begin
      // stage 1
      v1_q    <= div_i.valid;
      miss1_q <= div_i.miss || (tq < T_EPSILON) || (tq < div_i.side.tlo)
                 || (tq > div_i.side.thi);
      t1_q    <= tq;
      p0_q    <= 54'(tqs) * 54'(div_i.side.dx);
      p1_q    <= 54'(tqs) * 54'(div_i.side.dy);
      p2_q    <= 54'(tqs) * 54'(div_i.side.dz);
      ex1_q   <= div_i.side.ex;
      ey1_q   <= div_i.side.ey;
      ez1_q   <= div_i.side.ez;
      // stage 2
      v2_q    <= v1_q;
      miss2_q <= miss1_q;
      t2_q    <= t1_q;
      vx_q    <= 55'(p0_q) - (55'(ex1_q) <<< 16);
      vy_q    <= 55'(p1_q) - (55'(ey1_q) <<< 16);
      vz_q    <= 55'(p2_q) - (55'(ez1_q) <<< 16);
      // stage 3
      v3_q    <= v2_q;
      miss3_q <= miss2_q;
      t3_q    <= t2_q;
      ma0_q   <= 76'(vx_q) * 76'(side1_i.x);
      ma1_q   <= 76'(vy_q) * 76'(side1_i.y);
      ma2_q   <= 76'(vz_q) * 76'(side1_i.z);
      mb0_q   <= 76'(vx_q) * 76'(side2_i.x);
      mb1_q   <= 76'(vy_q) * 76'(side2_i.y);
      mb2_q   <= 76'(vz_q) * 76'(side2_i.z);
      lsa_q   <= 45'(42'(side1_i.x) * 42'(side1_i.x)) + 45'(42'(side1_i.y) * 42'(side1_i.y))
                 + 45'(42'(side1_i.z) * 42'(side1_i.z));
      lsb_q   <= 45'(42'(side2_i.x) * 42'(side2_i.x)) + 45'(42'(side2_i.y) * 42'(side2_i.y))
                 + 45'(42'(side2_i.z) * 42'(side2_i.z));
      // stage 4
      v4_q    <= v3_q;
      miss4_q <= miss3_q;
      t4_q    <= t3_q;
      pa_q    <= 78'(ma0_q) + 78'(ma1_q) + 78'(ma2_q);
      pb_q    <= 78'(mb0_q) + 78'(mb1_q) + 78'(mb2_q);
      la_q    <= 78'(lsa_q) <<< 16;
      lb_q    <= 78'(lsb_q) <<< 16;
      // result register
      out_v_q <= v4_q;
      hit_q   <= hit_d;
      hit_t_q <= hit_d ? t4_q : '0;
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.hit   = hit_q;
  assign res_o.hit_t = hit_t_q;

endmodule

/* sv/ray_rectangle_intersect.sv */
// channel   dir  fields                                        role
// ray_i     in   ray_origin_x/y/z, ray_dir_x/y/z, t_lower/upper one ray per transfer
// res_o     out  hit, hit_t                                    one result per ray
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i               corner, side one, side two
//
// one ray per cycle while no stalled result holds the pipeline; each result passes through
// 6 setup stages, 32 divider cells with one quotient bit each, and 5 check stages
// reset clears the stage valid bits and the rectangle registers
// a stalled result freezes the whole pipeline; ray_i.ready drops while it waits
module ray_rectangle_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rri_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rri_pkg::CfgDataW-1:0]  cfg_data_i,
  rri_ray_if.sink                       ray_i,
  rri_res_if.source                     res_o
);
  import rri_pkg::*;

  logic [CfgDataW-1:0] corner_q, side1_q, side2_q;
  vec3_t               corner, side1, side2;
  logic                en;
  div_t                chain [QuotW+1];

  // rectangle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      side1_q  <= '0;
      side2_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CORNER:   corner_q <= cfg_data_i;
        CFG_SIDE_ONE: side1_q  <= cfg_data_i;
        CFG_SIDE_TWO: side2_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign corner = corner_q;
  assign side1  = side1_q;
  assign side2  = side2_q;

  // pipeline advances unless a result is held
  assign en = !res_o.valid || res_o.ready;

  rri_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ray_i    (ray_i),
    .corner_i (corner),
    .side1_i  (side1),
    .side2_i  (side2),
    .div_o    (chain[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < QuotW; k++) begin : g_cell
    rri_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  rri_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .div_i   (chain[QuotW]),
    .side1_i (side1),
    .side2_i (side2),
    .res_o   (res_o)
  );

  // a hit never reports t below epsilon
  a_hit_eps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.hit |-> res_o.hit_t >= T_EPSILON)
    else $error("hit with t below epsilon");

  // a miss reports zero t
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit |-> res_o.hit_t == '0)
    else $error("miss with nonzero t");

  // t below the window of its ray as it leaves the divider is a miss
  a_div_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[QuotW].valid && !chain[QuotW].miss && en
    && (chain[QuotW].quot < chain[QuotW].side.tlo) |=> u_back.miss1_q)
    else $error("window test lost");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import rri_pkg::*;

  typedef struct packed {
    logic signed [20:0] ox;
    logic signed [20:0] oy;
    logic signed [20:0] oz;
    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic signed [20:0] dz;
    logic [31:0]        tlo;
    logic [31:0]        thi;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t;
  } result_t;

  localparam int unsigned        TimeoutCycles = 400000;
  localparam int unsigned        DrainCycles   = 60;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED    = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rri_ray_if ray_if ();
  rri_res_if res_if ();

  ray_rectangle_intersect uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ray_i      (ray_if),
    .res_o      (res_if)
  );

  // rectangle as the block should hold it
  logic [62:0] rect_corner, rect_side1, rect_side2;

  ray_t    rays_waiting[$];
  result_t hits_due[$];
  int      error_count;
  int      cycle_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      ray_taken;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sx21(logic [20:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [62:0] pack3(longint x, longint y, longint z);
    logic [20:0] px, py, pz;
    px = x[20:0];
    py = y[20:0];
    pz = z[20:0];
    return {pz, py, px};
  endfunction

  // exact intersection test with t truncated to Q16.16
  function automatic result_t intersect_ray(ray_t r);
    result_t res;
    longint c[3], s[2][3], o[3], dv[3], d[3], n[3], vv[3];
    longint den, lsq;
    logic signed [127:0] num, mag, p, a, b, lim;
    logic [63:0] nmag, dmag, tq;
    logic [127:0] qw;
    bit ok;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      c[i] = sx21(rect_corner[21*i +: 21]);
      s[0][i] = sx21(rect_side1[21*i +: 21]);
      s[1][i] = sx21(rect_side2[21*i +: 21]);
    end
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    dv[0] = r.dx; dv[1] = r.dy; dv[2] = r.dz;
    for (int i = 0; i < 3; i++) d[i] = c[i] - o[i];
    n[0] = s[1][1] * s[0][2] - s[1][2] * s[0][1];
    n[1] = s[1][2] * s[0][0] - s[1][0] * s[0][2];
    n[2] = s[1][0] * s[0][1] - s[1][1] * s[0][0];
    // denominator wraps at 64 bits
    den = dv[0] * n[0] + dv[1] * n[1] + dv[2] * n[2];
    if (den == 0) return res;
    num = 128'(d[0] * n[0]);
    num = num + 128'(d[1] * n[1]);
    num = num + 128'(d[2] * n[2]);
    mag = num[127] ? -num : num;
    nmag = mag[63:0];
    if (nmag != 0 && num[127] != (den < 0)) return res;
    dmag = (den < 0) ? 64'(-den) : 64'(den);
    if (nmag / dmag >= 64'd65536) return res;
    qw = ({64'd0, nmag} << 16) / {64'd0, dmag};
    tq = qw[63:0];
    if (tq < 64'(T_EPSILON)) return res;
    if (tq < 64'(r.tlo) || tq > 64'(r.thi)) return res;
    for (int i = 0; i < 3; i++) vv[i] = longint'(tq) * dv[i] - d[i] * 65536;
    // projections on both sides
    ok = 1'b1;
    for (int j = 0; j < 2; j++) begin
      p = '0;
      for (int i = 0; i < 3; i++) begin
        a = vv[i];
        b = s[j][i];
        p = p + a * b;
      end
      lsq = s[j][0] * s[j][0] + s[j][1] * s[j][1] + s[j][2] * s[j][2];
      lim = lsq * 65536;
      if (p < 0 || p > lim) ok = 1'b0;
    end
    if (!ok) return res;
    res.hit = 1'b1;
    res.t = tq[31:0];
    return res;
  endfunction

  // ray aimed at corner + (ai*S1 + bi*S2)/256, t about 4/fnum
  function automatic ray_t aimed_ray(int fnum, int ai, int bi);
    ray_t r;
    longint o[3], dv[3], p;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'($urandom_range(0, 262143)) - 131072;
      p = sx21(rect_corner[21*i +: 21]) + (sx21(rect_side1[21*i +: 21]) * ai
          + sx21(rect_side2[21*i +: 21]) * bi) / 256;
      dv[i] = ((p - o[i]) * fnum) / 4;
    end
    r.ox = o[0][20:0]; r.oy = o[1][20:0]; r.oz = o[2][20:0];
    r.dx = dv[0][20:0]; r.dy = dv[1][20:0]; r.dz = dv[2][20:0];
    r.tlo = '0;
    r.thi = '1;
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.ox = 21'($urandom); r.oy = 21'($urandom); r.oz = 21'($urandom);
    r.dx = 21'($urandom); r.dy = 21'($urandom); r.dz = 21'($urandom);
    r.tlo = $urandom;
    r.thi = $urandom;
    return r;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      r = aimed_ray($urandom_range(5, 8), $urandom_range(0, 300) - 20,
                    $urandom_range(0, 300) - 20);
      if ($urandom_range(0, 99) < 25) begin
        r.tlo = $urandom_range(0, 40000);
        r.thi = $urandom_range(20000, 65535);
      end
    end else if (sel < 80) begin
      r = aimed_ray($urandom_range(5, 8), $urandom_range(0, 256), $urandom_range(0, 256));
      r.dx = -r.dx; r.dy = -r.dy; r.dz = -r.dz;
    end else begin
      r = noise_ray();
    end
    return r;
  endfunction

  function automatic logic [62:0] rand_vec(int lim);
    return pack3(longint'($urandom_range(0, 2 * lim)) - lim,
                 longint'($urandom_range(0, 2 * lim)) - lim,
                 longint'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [62:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_CORNER:   rect_corner = val;
      CFG_SIDE_ONE: rect_side1 = val;
      CFG_SIDE_TWO: rect_side2 = val;
      default: ;
    endcase
  endtask

  task automatic queue_rays(int count);
    repeat (count) rays_waiting.push_back(random_ray());
  endtask

  task automatic wait_idle();
    wait (rays_waiting.size() == 0 && !ray_if.valid && hits_due.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // ray driver and result ready
  always @(negedge clk_i) begin : drv
    ray_t nr;
    if (rst_ni) begin
      if (!ray_if.valid || ray_taken) begin
        if (rays_waiting.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nr = rays_waiting.pop_front();
          ray_if.valid        <= 1'b1;
          ray_if.ray_origin_x <= nr.ox;
          ray_if.ray_origin_y <= nr.oy;
          ray_if.ray_origin_z <= nr.oz;
          ray_if.ray_dir_x    <= nr.dx;
          ray_if.ray_dir_y    <= nr.dy;
          ray_if.ray_dir_z    <= nr.dz;
          ray_if.t_lower      <= nr.tlo;
          ray_if.t_upper      <= nr.thi;
        end else begin
          ray_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each ray transfer, check on each result transfer
  always @(posedge clk_i) begin : mon
    ray_t    cur;
    result_t want;
    if (!rst_ni) begin
      ray_taken = 1'b0;
    end else begin
      cycle_count++;
      ray_taken = ray_if.valid && ray_if.ready;
      if (ray_taken) begin
        cur.ox  = ray_if.ray_origin_x;
        cur.oy  = ray_if.ray_origin_y;
        cur.oz  = ray_if.ray_origin_z;
        cur.dx  = ray_if.ray_dir_x;
        cur.dy  = ray_if.ray_dir_y;
        cur.dz  = ray_if.ray_dir_z;
        cur.tlo = ray_if.t_lower;
        cur.thi = ray_if.t_upper;
        hits_due.push_back(intersect_ray(cur));
      end
      if (res_if.valid && res_if.ready) begin
        if (hits_due.size() == 0) begin
          report_mismatch("unexpected result", res_if.hit_t, '0);
        end else begin
          want = hits_due.pop_front();
          if (res_if.hit != want.hit) report_mismatch("hit", 32'(res_if.hit), 32'(want.hit));
          if (res_if.hit_t != want.t) report_mismatch("hit_t", res_if.hit_t, want.t);
        end
      end
      if (cycle_count >= TimeoutCycles) begin
        $display("ray_rectangle_intersect regression: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 38;
    recv_idle_pct = 56;
    ray_taken     = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    rect_corner   = '0;
    rect_side1    = '0;
    rect_side2    = '0;
    ray_if.valid        = 1'b0;
    ray_if.ray_origin_x = '0;
    ray_if.ray_origin_y = '0;
    ray_if.ray_origin_z = '0;
    ray_if.ray_dir_x    = '0;
    ray_if.ray_dir_y    = '0;
    ray_if.ray_dir_z    = '0;
    ray_if.t_lower      = '0;
    ray_if.t_upper      = '0;
    res_if.ready        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // rectangle left at reset: every ray misses
    queue_rays(20);
    wait_idle();

    // first rectangle, sender and receiver both idle now and then
    write_reg(CFG_CORNER, pack3(-40960, -30720, 51200));
    write_reg(CFG_SIDE_ONE, pack3(81920, 0, 10240));
    write_reg(CFG_SIDE_TWO, pack3(0, 61440, -5120));
    queue_rays(180);
    // sender pauses until every result is back
    wait_idle();
    queue_rays(180);
    wait_idle();

    // unknown index is ignored, then a large rectangle
    send_idle_pct = 56;
    recv_idle_pct = 38;
    write_reg(CFG_UNUSED, pack3(1, 2, 3));
    write_reg(CFG_CORNER, pack3(300000, -500000, -200000));
    write_reg(CFG_SIDE_ONE, pack3(-400000, 250000, 100000));
    write_reg(CFG_SIDE_TWO, pack3(150000, 300000, -350000));
    queue_rays(360);
    wait_idle();

    // degenerate rectangle, sides parallel
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_SIDE_ONE, pack3(20000, -10000, 5000));
    write_reg(CFG_SIDE_TWO, pack3(40000, -20000, 10000));
    queue_rays(60);
    wait_idle();

    // random rectangle at full rate
    write_reg(CFG_CORNER, rand_vec(300000));
    write_reg(CFG_SIDE_ONE, rand_vec(200000));
    write_reg(CFG_SIDE_TWO, rand_vec(200000));
    queue_rays(300);
    wait_idle();

    if (error_count == 0) $display("ray_rectangle_intersect regression: pass");
    else $display("ray_rectangle_intersect regression: fail");
    $finish;
  end

endmodule
